// ===== hdl/flh32_pkg.sv =====
package flh32_pkg;

    localparam logic [31:0] K_MUL_X = 32'hcc9e2d51;
    localparam logic [31:0] K_MUL_H = 32'h1b873593;
    localparam logic [31:0] K_FIN   = 32'h1e35a7bd;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam int          PAD_TARGET = 12;
    localparam int          BLOCK_BYTES = 16;
    localparam int          NUM_LANES   = 4;
    localparam int          QUEUE_DEPTH = 2;

    typedef enum logic
    {
        KIND_BLOCK,
        KIND_FINAL
    } kind_t;

    // One queue transaction: a 16-byte block, byte j in bits 8j+7:8j.
    typedef struct packed
    {
        kind_t        kind;
        logic [127:0] block;
    } entry_t;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] lane_base(input logic [1:0] idx);
        logic [31:0] r;
        unique case (idx)
            2'd0: r = 32'he6546b69;
            2'd1: r = 32'h9e3779b1;
            2'd2: r = 32'h1e35a7bd;
            default: r = 32'hc2b2ae35;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/flh32_front.sv =====
module flh32_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_has,
    input  logic                in_last,
    output logic                push,
    output flh32_pkg::entry_t   push_entry,
    input  logic                q_full,
    output logic                msg_open
);
    import flh32_pkg::*;

    typedef enum logic
    {
        F_RUN,
        F_FLUSH
    } fstate_t;

    fstate_t     state_reg;
    logic [4:0]  fill_reg;
    logic [31:0] len_reg;
    logic        open_reg;
    logic        last_pend_reg;
    logic        mark_done_reg;
    logic [7:0]  buf_reg [BLOCK_BYTES];

    logic        accept;
    logic [127:0] pad_blk;
    logic [127:0] final_blk;

    assign in_ready = (state_reg == F_RUN);
    assign accept   = in_valid && in_ready;
    assign msg_open = open_reg;
    assign push     = (state_reg == F_FLUSH) && !q_full;

    // bytes below fill come from the buffer, then the pad mark (unless already placed), then zeros
    always_comb
    begin
        for (int j = 0; j < BLOCK_BYTES; j++)
        begin
            if (5'(j) < fill_reg)
                pad_blk[8*j +: 8] = buf_reg[j];
            else if ((5'(j) == fill_reg) && !mark_done_reg)
                pad_blk[8*j +: 8] = PAD_MARK;
            else
                pad_blk[8*j +: 8] = 8'h00;
        end
        final_blk = {len_reg, pad_blk[95:0]};
    end

    always_comb
    begin
        if (fill_reg == 5'(BLOCK_BYTES))
        begin
            push_entry.kind  = KIND_BLOCK;
            push_entry.block = pad_blk;
        end
        else if (fill_reg < 5'(PAD_TARGET))
        begin
            push_entry.kind  = KIND_FINAL;
            push_entry.block = final_blk;
        end
        else
        begin
            push_entry.kind  = KIND_BLOCK;
            push_entry.block = pad_blk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_has)
            buf_reg[fill_reg[3:0]] <= in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_RUN;
            fill_reg      <= '0;
            len_reg       <= '0;
            open_reg      <= 1'b0;
            last_pend_reg <= 1'b0;
            mark_done_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                F_RUN:
                begin
                    if (accept)
                    begin
                        if (in_has)
                        begin
                            fill_reg <= fill_reg + 5'd1;
                            len_reg  <= len_reg + 32'd1;
                            open_reg <= 1'b1;
                        end
                        last_pend_reg <= in_last;
                        if (in_last || (in_has && (fill_reg == 5'(BLOCK_BYTES - 1))))
                            state_reg <= F_FLUSH;
                    end
                end
                F_FLUSH:
                begin
                    if (push)
                    begin
                        fill_reg <= '0;
                        if (fill_reg == 5'(BLOCK_BYTES))
                        begin
                            state_reg <= last_pend_reg ? F_FLUSH : F_RUN;
                        end
                        else if (fill_reg < 5'(PAD_TARGET))
                        begin
                            len_reg       <= '0;
                            open_reg      <= 1'b0;
                            last_pend_reg <= 1'b0;
                            mark_done_reg <= 1'b0;
                            state_reg     <= F_RUN;
                        end
                        else
                        begin
                            // pad mark already placed, length goes in a second block
                            mark_done_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= F_RUN;
            endcase
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 5'(BLOCK_BYTES))
        else $error("fill count beyond block size");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (fill_reg < 5'(BLOCK_BYTES)) && !last_pend_reg)
        else $error("ready with a full block or pending finish");

endmodule

// ===== hdl/flh32_fifo.sv =====
module flh32_fifo
#(
    parameter int DEPTH = flh32_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  flh32_pkg::entry_t   push_entry,
    output logic                full,
    input  logic                pop,
    output flh32_pkg::entry_t   head,
    output logic                empty
);
    import flh32_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== hdl/flh32_back.sv =====
module flh32_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [31:0]         cfg_wdata,
    input  logic                msg_open,
    input  flh32_pkg::entry_t   head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_data
);
    import flh32_pkg::*;

    typedef enum logic [2:0]
    {
        B_IDLE,
        B_MULW,
        B_LANE,
        B_FLANE,
        B_FMULX,
        B_FACC,
        B_FOUT
    } bstate_t;

    bstate_t     state_reg;
    logic [1:0]  idx_reg;
    logic [31:0] lane_reg [NUM_LANES];
    logic [31:0] prod_reg;
    logic [31:0] acc_reg;
    logic [31:0] seed_reg;
    logic [31:0] out_reg;
    logic        out_valid_reg;

    logic [31:0] word;
    logic [31:0] mul_a;
    logic [31:0] mul_k;
    logic [31:0] mul_p;
    logic        slot_free;
    logic        last_lane;

    assign word      = head.block[{idx_reg, 5'd0} +: 32];
    assign slot_free = !out_valid_reg || out_ready;
    assign last_lane = (idx_reg == 2'(NUM_LANES - 1));
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign pop = ((state_reg == B_LANE) && last_lane && (head.kind == KIND_BLOCK))
              || ((state_reg == B_FOUT) && slot_free);

    // single shared multiplier, operands picked by step
    always_comb
    begin
        mul_a = word;
        mul_k = K_MUL_X;
        unique case (state_reg)
            B_MULW:
            begin
                mul_a = word;
                mul_k = K_MUL_X;
            end
            B_LANE:
            begin
                mul_a = rotl15(lane_reg[idx_reg] ^ prod_reg);
                mul_k = K_MUL_H;
            end
            B_FLANE:
            begin
                mul_a = rotl15(lane_reg[idx_reg]);
                mul_k = K_FIN;
            end
            B_FMULX:
            begin
                mul_a = prod_reg;
                mul_k = K_MUL_X;
            end
            B_FACC:
            begin
                mul_a = rotl15(acc_reg ^ prod_reg);
                mul_k = K_MUL_H;
            end
            B_FOUT:
            begin
                mul_a = rotl15(acc_reg);
                mul_k = K_FIN;
            end
            default:
            begin
                mul_a = word;
                mul_k = K_MUL_X;
            end
        endcase
        mul_p = mul_a * mul_k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            out_reg       <= '0;
            for (int i = 0; i < NUM_LANES; i++)
                lane_reg[i] <= lane_base(2'(i));
        end
        else
        begin
            if ((state_reg == B_FOUT) && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // seed write between messages reloads the lanes at once
            if (cfg_wen)
            begin
                seed_reg <= cfg_wdata;
                if (!msg_open)
                    for (int i = 0; i < NUM_LANES; i++)
                        lane_reg[i] <= lane_base(2'(i)) ^ cfg_wdata;
            end

            unique case (state_reg)
                B_IDLE:
                begin
                    idx_reg <= '0;
                    if (!empty)
                        state_reg <= B_MULW;
                end
                B_MULW:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= B_LANE;
                end
                B_LANE:
                begin
                    lane_reg[idx_reg] <= mul_p;
                    if (last_lane)
                    begin
                        idx_reg <= '0;
                        acc_reg <= '0;
                        state_reg <= (head.kind == KIND_FINAL) ? B_FLANE : B_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= B_MULW;
                    end
                end
                B_FLANE:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= B_FMULX;
                end
                B_FMULX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= B_FACC;
                end
                B_FACC:
                begin
                    acc_reg <= mul_p;
                    if (last_lane)
                        state_reg <= B_FOUT;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= B_FLANE;
                    end
                end
                B_FOUT:
                begin
                    if (slot_free)
                    begin
                        out_reg <= mul_p;
                        for (int i = 0; i < NUM_LANES; i++)
                            lane_reg[i] <= lane_base(2'(i)) ^ seed_reg;
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_final_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FLANE) |-> (head.kind == KIND_FINAL) && !empty)
        else $error("finalize without a final block at queue head");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_reg))
        else $error("pending hash lost or changed");

endmodule

// ===== hdl/four_lane_streaming_hash32.sv =====
// Throughput: one byte per cycle, with a flush state after each 16-byte block that waits
// for queue room; the lane sequencer works each block through its one 32x32 multiplier.
// After the last transaction, the final block runs the lane rounds, then lane finalize
// and fold and hash finalize; padding that spills adds a block, and queued blocks go first.
// Reset (rst_n, async, active low): seed 0, lanes at their start constants,
// empty queue, no partial block, no pending hash.
module four_lane_streaming_hash32
#(
    parameter int QUEUE_DEPTH = flh32_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: seed register
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // ends the message
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);
    import flh32_pkg::*;

    // Front: collects bytes into a 16-byte block buffer, counts the message
    // length, and builds padded final blocks. Each full, padded or final block is one
    // queue transaction.
    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   msg_open;

    // Back side of the queue.
    entry_t head;
    logic   q_empty;
    logic   pop;

    flh32_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_has     (s_tuser),
        .in_last    (s_tlast),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full),
        .msg_open   (msg_open)
    );

    // Short queue of blocks so byte intake and lane math stall independently.
    flh32_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    // Back: lane rounds, lane finalize and fold, hash finalize, all through a
    // single multiplier with a register after each product. Holds the seed and
    // reloads the seeded lanes after each hash (or on a seed write between
    // messages). The output register lets the next blocks proceed while a
    // hash waits to be taken.
    flh32_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .msg_open  (msg_open),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import flh32_pkg::*;

    // Run bounds: cycle budget before a timeout, and the quiet time after the
    // last expected hash (covers up to two queued blocks plus pad spill).
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TIME  = 80;
    localparam int RANDOM_ITEMS = 1850;

    // One input transaction as the stream carries it.
    typedef struct packed
    {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } stream_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    four_lane_streaming_hash32 DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Hash predictor: its own seed, lanes, partial block and byte count.
    // ------------------------------------------------------------------
    logic [31:0] hash_seed;
    logic [31:0] lane_h [4];
    logic [7:0]  blk_bytes [16];
    int          blk_fill;
    logic [31:0] msg_bytes;
    bit          msg_active;     // set once the current message took a byte

    logic [31:0] expected_hashes [$];
    stream_item_t pending_items [$];

    int mismatch_count = 0;
    int random_count = 0;
    int cycle_count = 0;

    // Idle knobs, switched per phase so some stretches run flat out.
    bit src_idle = 1'b0;
    bit sink_idle = 1'b0;

    function automatic logic [31:0] mix_round(input logic [31:0] h, input logic [31:0] x);
        logic [31:0] t;
        t = h ^ (x * K_MUL_X);
        return {t[16:0], t[31:17]} * K_MUL_H;
    endfunction

    function automatic logic [31:0] lane_close(input logic [31:0] h);
        return {h[16:0], h[31:17]} * K_FIN;
    endfunction

    task automatic seed_lanes();
        lane_h[0] = 32'he6546b69 ^ hash_seed;
        lane_h[1] = 32'h9e3779b1 ^ hash_seed;
        lane_h[2] = 32'h1e35a7bd ^ hash_seed;
        lane_h[3] = 32'hc2b2ae35 ^ hash_seed;
    endtask

    task automatic open_new_message();
        seed_lanes();
        blk_fill   = 0;
        msg_bytes  = '0;
        msg_active = 1'b0;
    endtask

    // Drop one byte into the block; a full block folds into the four lanes.
    task automatic absorb_byte(input logic [7:0] b);
        logic [31:0] w;
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == BLOCK_BYTES)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                w = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
                lane_h[i] = mix_round(lane_h[i], w);
            end
            blk_fill = 0;
        end
    endtask

    // Pad to 12 mod 16 (a full 16 when already at 12), append length, fold.
    task automatic compute_digest(output logic [31:0] digest);
        int pad;
        logic [31:0] h;
        pad = (blk_fill < PAD_TARGET) ? (PAD_TARGET - blk_fill)
                                      : (PAD_TARGET + BLOCK_BYTES - blk_fill);
        for (int k = 0; k < pad; k++)
            absorb_byte((k == 0) ? PAD_MARK : 8'h00);
        for (int k = 0; k < 4; k++)
            absorb_byte(msg_bytes[8*k +: 8]);
        h = '0;
        for (int i = 0; i < NUM_LANES; i++)
            h = mix_round(h, lane_close(lane_h[i]));
        digest = lane_close(h);
    endtask

    task automatic hash_item(input logic [7:0] d, input logic has, input logic fin);
        logic [31:0] digest;
        if (has)
        begin
            msg_active = 1'b1;
            msg_bytes  = msg_bytes + 32'd1;
            absorb_byte(d);
        end
        if (fin)
        begin
            compute_digest(digest);
            expected_hashes.push_back(digest);
            open_new_message();
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items, random gap after each transaction when src_idle is set.
    // ------------------------------------------------------------------
    int src_gap;
    stream_item_t next_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
            src_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                hash_item(s_tdata, s_tuser, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (src_gap != 0)
                begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.data;
                    s_tuser  <= next_item.has_byte;
                    s_tlast  <= next_item.last;
                    src_gap  <= src_idle ? $urandom_range(0, 10) : 0;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each hash transaction, then, when sink_idle is set, stalls a
    // random while before taking the next one.
    // ------------------------------------------------------------------
    int sink_gap;
    int sink_draw;
    logic [31:0] want_hash;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b1;
            sink_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $display("%0t: unexpected hash transaction: expected none, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want_hash = expected_hashes.pop_front();
                    if (m_tdata !== want_hash)
                    begin
                        $display("%0t: hash_value mismatch: expected %h, actual %h",
                                 $time, want_hash, m_tdata);
                        mismatch_count++;
                    end
                end
                sink_draw = sink_idle ? $urandom_range(0, 10) : 0;
                sink_gap <= sink_draw;
                m_tready <= (sink_draw == 0);
            end
            else if (!m_tready)
            begin
                // stall counts down only while a hash is waiting
                if (sink_gap == 0)
                    m_tready <= 1'b1;
                else if (m_tvalid)
                    sink_gap <= sink_gap - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d hashes outstanding", $time, expected_hashes.size());
            $display("four_lane_streaming_hash32 verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [7:0] d, input logic has, input logic fin,
                              input bit counted);
        stream_item_t it;
        it.data     = d;
        it.has_byte = has;
        it.last     = fin;
        pending_items.push_back(it);
        if (counted)
            random_count++;
    endtask

    // A message of len bytes with random content and scattered no-byte
    // items; closed ones end either on the final byte or on a no-byte last.
    task automatic queue_message(input int len, input bit closed, input bit counted);
        bit last_on_byte;
        last_on_byte = closed && (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, counted);
            queue_item(8'($urandom_range(0, 255)), 1'b1, last_on_byte && (k == len - 1),
                       counted);
        end
        if (closed && !last_on_byte)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, counted);
    endtask

    // All queued transactions taken, every hash back, then let the block drain.
    task automatic wait_quiet();
        while (pending_items.size() != 0 || s_tvalid || expected_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        hash_seed = v;
        // between messages the lanes pick up the new seed at once
        if (!msg_active)
            seed_lanes();
    endtask

    function automatic int draw_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 20);
        else if (r < 9)
            return $urandom_range(21, 48);
        return $urandom_range(49, 80);
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int pick;
    logic [31:0] seed_val;

    initial
    begin
        hash_seed = '0;
        open_new_message();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset seed, empty message, single extreme bytes, a
        // lone no-byte item, 12 bytes (full pad block), no-byte last.
        queue_item(8'h00, 1'b0, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1, 1'b0);
        queue_item(8'hff, 1'b1, 1'b1, 1'b0);
        queue_item(8'hff, 1'b0, 1'b0, 1'b0);
        for (int k = 0; k < 12; k++)
            queue_item((k % 2 == 0) ? 8'hff : 8'h00, 1'b1, k == 11, 1'b0);
        queue_item(8'h5a, 1'b1, 1'b0, 1'b0);
        queue_item(8'ha5, 1'b1, 1'b0, 1'b0);
        queue_item(8'h3c, 1'b1, 1'b0, 1'b0);
        queue_item(8'hff, 1'b0, 1'b1, 1'b0);
        wait_quiet();

        // All-ones seed, empty message, then a seed change mid-message.
        write_seed(32'hffffffff);
        queue_item(8'h00, 1'b0, 1'b1, 1'b0);
        queue_item(8'h81, 1'b1, 1'b0, 1'b0);
        queue_item(8'h7e, 1'b1, 1'b0, 1'b0);
        wait_quiet();
        write_seed(32'h12345678);
        queue_item(8'h01, 1'b1, 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1, 1'b0);
        wait_quiet();

        // Random phases: new seed and idle mix per phase, a handful of
        // messages, sometimes leaving one open across the next seed write.
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        while (random_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                seed_val = 32'h00000000;
            else if (pick == 1)
                seed_val = 32'hffffffff;
            else
                seed_val = $urandom;
            write_seed(seed_val);
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            for (int m = $urandom_range(3, 8); m > 0; m--)
                queue_message(draw_length(), 1'b1, 1'b1);
            if ($urandom_range(0, 3) == 0)
                queue_message($urandom_range(1, 20), 1'b0, 1'b1);
            wait_quiet();
        end
        queue_message(draw_length(), 1'b1, 1'b1);
        wait_quiet();

        if (mismatch_count == 0)
            $display("four_lane_streaming_hash32 verification clean");
        else
            $display("four_lane_streaming_hash32 verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/flh32_pkg.sv
hdl/flh32_front.sv
hdl/flh32_fifo.sv
hdl/flh32_back.sv
hdl/four_lane_streaming_hash32.sv
tb/tb_top.sv
